>>> rtl/sshd_pkg.sv
// ----------------------------------------------------------------------------
// sshd_pkg - shared types and constants of the sync search header deframer
// Result record, phase and register codes, header field layout.
// ----------------------------------------------------------------------------
package sshd_pkg;

   localparam int unsigned FieldCount = 14;
   localparam logic [16:0] PosMax     = 17'h1FFFF;
   localparam logic [16:0] LimitReset = 17'd100000;

   typedef enum logic [1:0] {
      PH_SEARCH = 2'd0,
      PH_HEADER = 2'd1,
      PH_IDLE   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_SYNC  = 2'd0,
      KIND_FIELD = 2'd1,
      KIND_FAIL  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CSR_SYNC_PATTERN = 2'd0,
      CSR_SEARCH_LIMIT = 2'd1,
      CSR_SWAP_BYTES   = 2'd2
   } csr_index_type;

   localparam logic [3:0] LastField = 4'd13;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  field_index;
      logic [63:0] value;
      logic        last;
   } result_type;

   typedef struct packed {
      logic       done;
      logic [3:0] field_index;
      logic       last;
   } field_status_type;

   // Byte length of each header field, in file order.
   function automatic logic [3:0] field_len(input logic [3:0] idx);
      logic [3:0] len;
      case (idx)
         4'd0, 4'd1:                         len = 4'd2;
         4'd3, 4'd10, 4'd11, 4'd12, 4'd13:   len = 4'd4;
         default:                            len = 4'd8;
      endcase
      return len;
   endfunction

endpackage

>>> rtl/sshd_cell.sv
// ----------------------------------------------------------------------------
// sshd_cell - one byte of the sliding sync window
// Holds a byte, hands it on to the next cell, and compares the byte it
// takes in against its byte of the sync pattern.
// ----------------------------------------------------------------------------
module sshd_cell (
   input  logic       clock,
   input  logic       reset,
   input  logic       shift,
   input  logic [7:0] d_in,
   input  logic [7:0] pattern,
   output logic [7:0] q,
   output logic       hit
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   assign byte_in = shift ? d_in : byte_ff;
   assign q       = byte_ff;
   // compare the incoming byte: it is the window content after this shift
   assign hit     = (d_in == pattern);

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
      end else begin
         byte_ff <= byte_in;
      end
   end

endmodule

>>> rtl/sshd_hdr.sv
// ----------------------------------------------------------------------------
// sshd_hdr - header field assembler
// Collects header bytes into fields of 2, 4 or 8 bytes and flags each
// completed field together with its assembled bits.
// ----------------------------------------------------------------------------
module sshd_hdr (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear,
   input  logic                      step,
   input  logic [7:0]                data_byte,
   input  logic                      swap,
   output sshd_pkg::field_status_type status,
   output logic [63:0]               value
);

   logic [3:0]  field_ff, field_in;
   logic [3:0]  fbyte_ff, fbyte_in;
   logic [63:0] asm_ff, asm_in;
   logic [63:0] asm_next;
   logic [3:0]  fbyte_next;
   logic        done;

   assign fbyte_next = fbyte_ff + 4'd1;
   assign done       = step && (fbyte_next == sshd_pkg::field_len(field_ff));

   always_comb begin
      if (swap) begin
         asm_next = {asm_ff[55:0], data_byte};
      end else begin
         asm_next = asm_ff | ({56'd0, data_byte} << {fbyte_ff[2:0], 3'b000});
      end
   end

   assign status.done        = done;
   assign status.field_index = field_ff;
   assign status.last        = (field_ff == sshd_pkg::LastField);
   assign value              = asm_next;

   always_comb begin
      field_in = field_ff;
      fbyte_in = fbyte_ff;
      asm_in   = asm_ff;
      if (clear) begin
         field_in = 4'd0;
         fbyte_in = 4'd0;
         asm_in   = 64'd0;
      end else if (done) begin
         fbyte_in = 4'd0;
         asm_in   = 64'd0;
         if (field_ff != sshd_pkg::LastField) begin
            field_in = field_ff + 4'd1;
         end
      end else if (step) begin
         fbyte_in = fbyte_next;
         asm_in   = asm_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff <= 4'd0;
         fbyte_ff <= 4'd0;
         asm_ff   <= 64'd0;
      end else begin
         field_ff <= field_in;
         fbyte_ff <= fbyte_in;
         asm_ff   <= asm_in;
      end
   end

endmodule

>>> rtl/sshd_out.sv
// ----------------------------------------------------------------------------
// sshd_out - result output register with skid stage
// Two-entry output buffer; stall towards the input side is registered.
// ----------------------------------------------------------------------------
module sshd_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sshd_pkg::result_type push_data,
   output logic                full,
   output logic                out_valid,
   input  logic                out_stall,
   output sshd_pkg::result_type out_data
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   sshd_pkg::result_type main_ff, main_in;
   sshd_pkg::result_type skid_ff, skid_in;
   logic                 pop;

   assign pop       = main_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!main_valid_ff || pop) begin
         main_valid_in = push;
         main_in       = push_data;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

>>> rtl/sync_search_header_deframer.sv
// ----------------------------------------------------------------------------
// sync_search_header_deframer - sync word search and header deframer
// Finds a sync pattern in a byte stream and cuts the following 80-byte
// header into 14 fields.
// ----------------------------------------------------------------------------
// Takes one stream byte per cycle, every cycle, for as long as the result
// side keeps up: the search compare is done combinationally across a row
// of SYNC_BYTES byte cells, and each header byte is folded into the field
// in the same cycle. A result is registered in the output buffer before it
// appears on the rsp_ port. A two-entry output buffer lets requests keep
// flowing while a result waits; req_stall rises only once both entries are
// full. A request with req_restart set starts a new stream at that byte
// (offset 0). The block reports the sync offset (kind 0), then the 14 header
// fields (kind 1, last set on field 13), or a single failure (kind 2, last
// set) when no match starts at or below search_limit; after the last field
// or a failure it drops bytes until the next restart. Registers are written
// through csr_write_en/csr_index/csr_wdata: 0 sync_pattern, 1 search_limit,
// 2 swap_bytes; write them only while the block is idle.
module sync_search_header_deframer #(
   parameter int unsigned SYNC_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_restart,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_field_index,
   output logic [63:0] rsp_value,
   output logic        rsp_last,
   // configuration
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   localparam logic [16:0] SyncBytesW = 17'(SYNC_BYTES);

   // configuration registers
   logic [63:0] pattern_ff, pattern_in;
   logic [16:0] limit_ff, limit_in;
   logic        swap_ff, swap_in;

   // search state
   sshd_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic [16:0] pos_ff, pos_in;
   logic [16:0] pos_cur, pos_next, start;
   logic        saturated, window_full, window_hit;
   logic        accept, search_step, header_step;
   logic        found, failed;

   // cell row
   logic [SYNC_BYTES-1:0] hits;
   logic [7:0]            cell_q [SYNC_BYTES];

   // header and output
   sshd_pkg::field_status_type fstat;
   logic [63:0]                fvalue;
   sshd_pkg::result_type       res;
   sshd_pkg::result_type       rsp_data;
   logic                       push, out_full;

   assign req_stall = out_full;
   assign accept    = req_valid && !out_full;

   // -------------------------------------------------------------------------
   // configuration writes
   // -------------------------------------------------------------------------
   always_comb begin
      pattern_in = pattern_ff;
      limit_in   = limit_ff;
      swap_in    = swap_ff;
      if (csr_write_en) begin
         case (csr_index)
            sshd_pkg::CSR_SYNC_PATTERN: pattern_in = csr_wdata;
            sshd_pkg::CSR_SEARCH_LIMIT: limit_in   = csr_wdata[16:0];
            sshd_pkg::CSR_SWAP_BYTES:   swap_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= 64'd0;
         limit_ff   <= sshd_pkg::LimitReset;
         swap_ff    <= 1'b1;
      end else begin
         pattern_ff <= pattern_in;
         limit_ff   <= limit_in;
         swap_ff    <= swap_in;
      end
   end

   // -------------------------------------------------------------------------
   // window cells: cell 0 holds the newest byte, data moves towards the top
   // -------------------------------------------------------------------------
   for (genvar k = 0; k < SYNC_BYTES; k++) begin : g_cell
      logic [7:0] d_in;
      if (k == 0) begin : g_head
         assign d_in = req_data_byte;
      end else begin : g_body
         assign d_in = cell_q[k-1];
      end
      sshd_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .shift   (search_step),
         .d_in    (d_in),
         .pattern (pattern_ff[8*k +: 8]),
         .q       (cell_q[k]),
         .hit     (hits[k])
      );
   end

   assign window_hit = &hits;

   // -------------------------------------------------------------------------
   // search control: a restart clears the search before this byte is used
   // -------------------------------------------------------------------------
   assign phase_cur   = req_restart ? sshd_pkg::PH_SEARCH : phase_ff;
   assign pos_cur     = req_restart ? 17'd0 : pos_ff;
   assign saturated   = (pos_cur == sshd_pkg::PosMax);
   assign pos_next    = saturated ? pos_cur : pos_cur + 17'd1;
   assign window_full = (pos_next >= SyncBytesW);
   assign start       = pos_next - SyncBytesW;
   assign search_step = accept && (phase_cur == sshd_pkg::PH_SEARCH);
   assign header_step = accept && (phase_cur == sshd_pkg::PH_HEADER);

   assign found  = search_step && window_full && !saturated && window_hit &&
                   (start <= limit_ff);
   assign failed = search_step && window_full && !found &&
                   (saturated || (start >= limit_ff));

   // -------------------------------------------------------------------------
   // header fields
   // -------------------------------------------------------------------------
   sshd_hdr u_hdr (
      .clock     (clock),
      .reset     (reset),
      .clear     (found),
      .step      (header_step),
      .data_byte (req_data_byte),
      .swap      (swap_ff),
      .status    (fstat),
      .value     (fvalue)
   );

   // -------------------------------------------------------------------------
   // phase machine and result selection
   // -------------------------------------------------------------------------
   always_comb begin
      phase_in        = phase_ff;
      pos_in          = pos_ff;
      push            = 1'b0;
      res.kind        = sshd_pkg::KIND_SYNC;
      res.field_index = 4'd0;
      res.value       = 64'd0;
      res.last        = 1'b0;
      if (accept) begin
         phase_in = phase_cur;
         pos_in   = pos_cur;
         case (phase_cur)
            sshd_pkg::PH_SEARCH: begin
               pos_in = pos_next;
               if (found) begin
                  phase_in  = sshd_pkg::PH_HEADER;
                  push      = 1'b1;
                  res.value = {47'd0, start};
               end else if (failed) begin
                  phase_in = sshd_pkg::PH_IDLE;
                  push     = 1'b1;
                  res.kind = sshd_pkg::KIND_FAIL;
                  res.last = 1'b1;
               end
            end
            sshd_pkg::PH_HEADER: begin
               if (fstat.done) begin
                  push            = 1'b1;
                  res.kind        = sshd_pkg::KIND_FIELD;
                  res.field_index = fstat.field_index;
                  res.value       = fvalue;
                  res.last        = fstat.last;
                  if (fstat.last) begin
                     phase_in = sshd_pkg::PH_IDLE;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sshd_pkg::PH_SEARCH;
         pos_ff   <= 17'd0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
   end

   // -------------------------------------------------------------------------
   // output buffer
   // -------------------------------------------------------------------------
   sshd_out u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (res),
      .full      (out_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_kind        = rsp_data.kind;
   assign rsp_field_index = rsp_data.field_index;
   assign rsp_value       = rsp_data.value;
   assign rsp_last        = rsp_data.last;

`ifndef SYNTHESIS
   // a held skid entry always sits behind a held main entry
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      out_full |-> rsp_valid)
      else $error("skid entry held without main entry");

   // a window never both matches and fails
   a_found_xor_failed: assert property (@(posedge clock) disable iff (reset)
      !(found && failed))
      else $error("sync found and search failed together");

   // idle drops bytes until a restart
   a_idle_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_restart && phase_ff == sshd_pkg::PH_IDLE) |-> !push)
      else $error("result produced while idle");

   // header fields only follow a sync result
   a_header_after_sync: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == sshd_pkg::PH_SEARCH && phase_in == sshd_pkg::PH_HEADER) |-> found)
      else $error("header phase entered without sync");
`endif

endmodule
